### design/btk_pkg.sv
package btk_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SYNC  = 2'd1,
        OP_START = 2'd2,
        OP_NOP   = 2'd3
    } btk_op_t;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PERIOD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ON_SYNC = 1'd1;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [23:0] ALARM_PERIOD_RESET = 24'd8640;

    localparam logic [16:0] BEAT_LAST = 17'd99999;

    // sync arithmetic constants
    localparam logic [9:0] MS_PER_SEC = 10'd1000;
    // rounding half (1000) + zone shift (3600 s * 2000) - twice the era offset in ms
    localparam logic signed [49:0] Y_BIAS = -50'sd4417970399000;
    // seconds-of-day modulus over 1024: 86400 * 2000 / 1024
    localparam int unsigned MOD_M = 168750;
    localparam logic [15:0] FOLD_C = 16'd36076;
    localparam logic [40:0] MOD_BIAS = 41'd549755943750;
    localparam logic [24:0] RECIP_125 = 25'd17179870;
    localparam logic [22:0] RECIP_27 = 23'd4971027;
    localparam logic [6:0] TOD_TO_BEAT_MUL = 7'd125;

    localparam int unsigned FRONT_STAGES = 14;
    localparam int unsigned LO_STAGES = 7;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] client_send_ms;
        logic [47:0] client_recv_ms;
        logic [31:0] server_recv_sec;
        logic [31:0] server_recv_frac;
        logic [31:0] server_xmit_sec;
        logic [31:0] server_xmit_frac;
    } in_beat_t;

    typedef struct packed {
        logic [16:0] beat_value;
        logic        beat_advanced;
        logic        is_running;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [16:0] load_beat;
    } btk_cmd_t;

    typedef struct packed {
        logic [23:0] alarm_period;
        logic        start_on_sync;
    } btk_cfg_t;

endpackage

### design/btk_front.sv
module btk_front import btk_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  in_beat_t in_data,
    output logic     in_ready,
    output logic     cmd_valid,
    output btk_cmd_t cmd_data,
    input  logic     cmd_ready
);

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [1:0]              op_reg [FRONT_STAGES];
    logic [5:0]              lo_reg [LO_STAGES];

    logic [41:0]        s1_sr_reg;
    logic [41:0]        s1_sx_reg;
    logic [9:0]         s1_fr_reg;
    logic [9:0]         s1_fx_reg;
    logic signed [48:0] s1_dt_reg;
    logic [42:0]        s2_sum_reg;
    logic signed [48:0] s2_dt_reg;
    logic signed [49:0] s3_y_reg;
    logic [40:0]        s4_zp_reg;
    logic [36:0]        f1_reg;
    logic [32:0]        f2_reg;
    logic [28:0]        f3_reg;
    logic [24:0]        f4_reg;
    logic [21:0]        f5_reg;
    logic [20:0]        f6_reg;
    logic [23:0]        x_reg;
    logic [48:0]        d1_reg;
    logic [23:0]        d2_reg;
    logic [44:0]        d3_reg;

    logic        en;
    logic [41:0] fr_prod;
    logic [41:0] fx_prod;
    logic [20:0] rem;
    logic [16:0] tod;

    assign en       = !vld_reg[FRONT_STAGES-1] || cmd_ready;
    assign in_ready = en;

    assign fr_prod = 42'(in_data.server_recv_frac) * 42'(MS_PER_SEC);
    assign fx_prod = 42'(in_data.server_xmit_frac) * 42'(MS_PER_SEC);

    // final reduction of the folded value, below seven moduli
    always_comb begin
        rem = f6_reg;
        for (int k = 1; k < 7; k++) begin
            if (f6_reg >= 21'(k * MOD_M)) begin
                rem = f6_reg - 21'(k * MOD_M);
            end
        end
    end

    assign tod = d1_reg[47:31];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg[0] <= in_data.op;
            for (int i = 1; i < FRONT_STAGES; i++) begin
                op_reg[i] <= op_reg[i-1];
            end
            lo_reg[0] <= s3_y_reg[9:4];
            for (int i = 1; i < LO_STAGES; i++) begin
                lo_reg[i] <= lo_reg[i-1];
            end

            // server times in ms, client round trip
            s1_sr_reg <= 42'(in_data.server_recv_sec) * 42'(MS_PER_SEC);
            s1_sx_reg <= 42'(in_data.server_xmit_sec) * 42'(MS_PER_SEC);
            s1_fr_reg <= fr_prod[41:32];
            s1_fx_reg <= fx_prod[41:32];
            s1_dt_reg <= $signed({1'b0, in_data.client_recv_ms})
                         - $signed({1'b0, in_data.client_send_ms});

            s2_sum_reg <= 43'(s1_sr_reg) + 43'(s1_sx_reg) + 43'(s1_fr_reg) + 43'(s1_fx_reg);
            s2_dt_reg  <= s1_dt_reg;

            s3_y_reg <= 50'(s2_dt_reg) + $signed({7'd0, s2_sum_reg}) + Y_BIAS;

            // floor by 1024, biased positive by a multiple of the modulus
            s4_zp_reg <= 41'(s3_y_reg >>> 10) + MOD_BIAS;

            // fold high bits back with 2^20 mod modulus
            f1_reg <= 37'(s4_zp_reg[40:20]) * 37'(FOLD_C) + 37'(s4_zp_reg[19:0]);
            f2_reg <= 33'(f1_reg[36:20]) * 33'(FOLD_C) + 33'(f1_reg[19:0]);
            f3_reg <= 29'(f2_reg[32:20]) * 29'(FOLD_C) + 29'(f2_reg[19:0]);
            f4_reg <= 25'(f3_reg[28:20]) * 25'(FOLD_C) + 25'(f3_reg[19:0]);
            f5_reg <= 22'(f4_reg[24:20]) * 22'(FOLD_C) + 22'(f4_reg[19:0]);
            f6_reg <= 21'(f5_reg[21:20]) * 21'(FOLD_C) + 21'(f5_reg[19:0]);

            x_reg <= {rem[17:0], lo_reg[LO_STAGES-1]};

            // seconds of day = x / 125, then beats = tod * 125 / 108
            d1_reg <= 49'(x_reg) * 49'(RECIP_125);
            d2_reg <= 24'(tod) * 24'(TOD_TO_BEAT_MUL);
            d3_reg <= 45'(d2_reg[23:2]) * 45'(RECIP_27);
        end
    end

    assign cmd_valid          = vld_reg[FRONT_STAGES-1];
    assign cmd_data.op        = op_reg[FRONT_STAGES-1];
    assign cmd_data.load_beat = d3_reg[43:27];

endmodule

### design/btk_fifo.sv
module btk_fifo import btk_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    input  btk_cmd_t push_data,
    output logic     push_ready,
    output logic     pop_valid,
    output btk_cmd_t pop_data,
    input  logic     pop
);

    btk_cmd_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = count_reg != (FIFO_AW+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/btk_back.sv
module btk_back import btk_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  btk_cfg_t  cfg,
    input  logic      cmd_valid,
    input  btk_cmd_t  cmd_data,
    output logic      cmd_pop,
    output logic      out_valid,
    output out_beat_t out_data,
    input  logic      out_ready
);

    logic [16:0] beat_count_reg;
    logic [16:0] beat_count_next;
    logic [23:0] prescale_reg;
    logic [23:0] prescale_next;
    logic        running_reg;
    logic        running_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_beat_t   out_data_reg;
    out_beat_t   out_data_next;
    logic        advanced;
    logic [23:0] prescale_inc;

    assign cmd_pop      = cmd_valid && (!out_valid_reg || out_ready);
    assign prescale_inc = prescale_reg + 1'b1;

    always_comb begin
        beat_count_next = beat_count_reg;
        prescale_next   = prescale_reg;
        running_next    = running_reg;
        advanced        = 1'b0;
        case (cmd_data.op)
            OP_TICK: begin
                if (running_reg) begin
                    prescale_next = prescale_inc;
                    if (prescale_inc >= cfg.alarm_period) begin
                        prescale_next   = '0;
                        advanced        = 1'b1;
                        beat_count_next = (beat_count_reg >= BEAT_LAST) ? '0
                                          : beat_count_reg + 1'b1;
                    end
                end
            end
            OP_SYNC: begin
                beat_count_next = cmd_data.load_beat;
                if (cfg.start_on_sync) begin
                    running_next = 1'b1;
                end
            end
            OP_START: begin
                running_next = 1'b1;
            end
            default: begin
            end
        endcase
        out_data_next.beat_value    = beat_count_next;
        out_data_next.beat_advanced = advanced;
        out_data_next.is_running    = running_next;
        out_valid_next = cmd_pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_count_reg <= '0;
            prescale_reg   <= '0;
            running_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd_pop) begin
                beat_count_reg <= beat_count_next;
                prescale_reg   <= prescale_next;
                running_reg    <= running_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/beat_time_keeper_with_ntp_sync.sv
// Time-of-day clock in centibeats (0..99999) with SNTP-based loading. Every beat on the
// s_ channel yields exactly one beat on the m_ channel, in order: a tick advances the
// prescaler while running, a sync loads the count from the four exchange timestamps
// (rounded to whole seconds, shifted to UTC+1) and, if start_on_sync is set, starts the
// clock; a start sets the clock running. One beat is taken per cycle unless m_ready
// stalls; the rate is set by the state update in the back end, which applies one beat
// per cycle. Each beat runs through a 14-stage arithmetic pipeline (millisecond
// conversion, folded modulo reduction, reciprocal multiplies) and a 4-entry queue. The
// user writes registers through cfg_we/cfg_index/cfg_wdata only while no beat is in
// flight (index 0 alarm_period, index 1 start_on_sync); the block does not enforce this.
module beat_time_keeper_with_ntp_sync import btk_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [23:0] alarm_period_reg;
    logic [23:0] alarm_period_next;
    logic        start_on_sync_reg;
    logic        start_on_sync_next;
    btk_cfg_t    cfg;

    logic     f_valid;
    btk_cmd_t f_data;
    logic     q_ready;
    logic     q_valid;
    btk_cmd_t q_data;
    logic     q_pop;

    always_comb begin
        alarm_period_next  = alarm_period_reg;
        start_on_sync_next = start_on_sync_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ALARM_PERIOD:  alarm_period_next  = cfg_wdata[23:0];
                CFG_START_ON_SYNC: start_on_sync_next = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_period_reg  <= ALARM_PERIOD_RESET;
            start_on_sync_reg <= 1'b0;
        end else begin
            alarm_period_reg  <= alarm_period_next;
            start_on_sync_reg <= start_on_sync_next;
        end
    end

    assign cfg.alarm_period  = alarm_period_reg;
    assign cfg.start_on_sync = start_on_sync_reg;

    btk_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .in_ready  (s_ready),
        .cmd_valid (f_valid),
        .cmd_data  (f_data),
        .cmd_ready (q_ready)
    );

    btk_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_data  (f_data),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (q_pop)
    );

    btk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (q_valid),
        .cmd_data  (q_data),
        .cmd_pop   (q_pop),
        .out_valid (m_valid),
        .out_data  (m_data),
        .out_ready (m_ready)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.beat_value <= BEAT_LAST)
        else $error("beat value beyond end of day");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.beat_advanced |-> m_data.is_running)
        else $error("beat advanced while stopped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> f_valid && !q_ready)
        else $error("input stalled without a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

### bench/tb_beat_time_keeper_with_ntp_sync.sv
module tb_beat_time_keeper_with_ntp_sync;
    import btk_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned RX_HOLD_CYCLES = 80;
    localparam int unsigned RAND_PHASES = 6;
    localparam int unsigned PHASE_BEATS = 270;
    localparam logic [31:0] NTP_ERA_S = 32'd2208988800;
    localparam longint NTP_ERA_MS = 64'sd2208988800000;
    localparam longint DAY_SECONDS = 86400;
    localparam longint ZONE_SECONDS = 3600;
    localparam logic [16:0] BEATS_LAST = 17'd99999;
    localparam int unsigned DAY_END_UNIX_S = 82799;

    class beat_scoreboard;
        logic [23:0] alarm_period;
        logic        start_on_sync;
        logic [16:0] beat_count;
        logic [23:0] prescale;
        logic        running;
        out_beat_t   expected_q[$];
        int unsigned beats_in;
        int unsigned results_checked;
        int unsigned mismatches;
        int unsigned syncs;
        int unsigned advances;
        int unsigned wraps;

        function new();
            alarm_period = ALARM_PERIOD_RESET;
            start_on_sync = 1'b0;
            beat_count = '0;
            prescale = '0;
            running = 1'b0;
        endfunction

        function void set_config(logic [23:0] period, logic sos);
            alarm_period = period;
            start_on_sync = sos;
        endfunction

        function longint server_ms(logic [31:0] sec, logic [31:0] frac);
            logic [63:0] frac_prod;
            frac_prod = {32'b0, frac} * 64'd1000;
            return longint'({32'b0, sec}) * 1000 + longint'(frac_prod >> 32) - NTP_ERA_MS;
        endfunction

        function logic [16:0] beat_from_sync(in_beat_t b);
            longint t1, t2, t3, t4, twice, secs, tod;
            t1 = longint'({16'b0, b.client_send_ms});
            t4 = longint'({16'b0, b.client_recv_ms});
            t2 = server_ms(b.server_recv_sec, b.server_recv_frac);
            t3 = server_ms(b.server_xmit_sec, b.server_xmit_frac);
            twice = 2 * t4 + (t2 - t1) + (t3 - t4);
            secs = (twice + 1000) / 2000;
            if ((twice + 1000) % 2000 < 0) begin
                secs = secs - 1;
            end
            tod = (secs + ZONE_SECONDS) % DAY_SECONDS;
            if (tod < 0) begin
                tod = tod + DAY_SECONDS;
            end
            return 17'((tod * 125) / 108);
        endfunction

        function void note_input(in_beat_t b);
            out_beat_t exp_beat;
            logic      adv;
            adv = 1'b0;
            beats_in++;
            case (btk_op_t'(b.op))
                OP_TICK: begin
                    if (running) begin
                        prescale = prescale + 24'd1;
                        if (prescale >= alarm_period) begin
                            prescale = '0;
                            adv = 1'b1;
                            advances++;
                            if (beat_count >= BEATS_LAST) begin
                                beat_count = '0;
                                wraps++;
                            end else begin
                                beat_count = beat_count + 17'd1;
                            end
                        end
                    end
                end
                OP_SYNC: begin
                    syncs++;
                    beat_count = beat_from_sync(b);
                    if (start_on_sync) begin
                        running = 1'b1;
                    end
                end
                OP_START: begin
                    running = 1'b1;
                end
                default: begin
                end
            endcase
            exp_beat.beat_value = beat_count;
            exp_beat.beat_advanced = adv;
            exp_beat.is_running = running;
            expected_q.push_back(exp_beat);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat %0d adv %0b run %0b",
                             got.beat_value, got.beat_advanced, got.is_running);
                end
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (got.beat_value !== want.beat_value || got.beat_advanced !== want.beat_advanced
                    || got.is_running !== want.is_running) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             results_checked, want.beat_value, want.beat_advanced,
                             want.is_running, got.beat_value, got.beat_advanced,
                             got.is_running);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          rx_hold_req;
    int unsigned cycle_count;

    beat_scoreboard sb = new();

    beat_time_keeper_with_ntp_sync u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_beat_t noise_beat();
        in_beat_t    b;
        logic [63:0] r;
        r = {$urandom, $urandom};
        b.client_send_ms = r[47:0];
        r = {$urandom, $urandom};
        b.client_recv_ms = r[47:0];
        b.server_recv_sec = $urandom;
        b.server_recv_frac = $urandom;
        b.server_xmit_sec = $urandom;
        b.server_xmit_frac = $urandom;
        b.op = 2'($urandom_range(0, 3));
        return b;
    endfunction

    function automatic in_beat_t sync_at(int unsigned unix_s, logic [31:0] frac);
        in_beat_t b;
        b = '0;
        b.op = OP_SYNC;
        b.server_recv_sec = unix_s + NTP_ERA_S;
        b.server_xmit_sec = unix_s + NTP_ERA_S;
        b.server_recv_frac = frac;
        b.server_xmit_frac = frac;
        return b;
    endfunction

    // mostly a plausible exchange; a quarter are raw random timestamps
    function automatic in_beat_t rand_sync();
        in_beat_t    b;
        logic [63:0] r;
        int unsigned unix_s;
        b = noise_beat();
        b.op = OP_SYNC;
        if ($urandom_range(0, 3) == 0) begin
            return b;
        end
        if ($urandom_range(0, 3) == 0) begin
            unix_s = $urandom_range(0, 20000) * 86400 + DAY_END_UNIX_S - $urandom_range(0, 2);
        end else begin
            unix_s = $urandom_range(0, 2000000000);
        end
        r = {$urandom, $urandom};
        b.client_send_ms = {1'b0, r[46:0]};
        b.client_recv_ms = b.client_send_ms + 48'($urandom_range(0, 3000));
        b.server_recv_sec = unix_s + NTP_ERA_S;
        b.server_xmit_sec = b.server_recv_sec + 32'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic in_beat_t random_beat();
        in_beat_t    b;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        b = noise_beat();
        if (pick < 72) begin
            b.op = OP_TICK;
        end else if (pick < 84) begin
            b = rand_sync();
        end else if (pick < 90) begin
            b.op = OP_START;
        end else if (pick < 95) begin
            b.op = OP_NOP;
        end
        return b;
    endfunction

    task automatic send_beat(in_beat_t b);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(b);
    endtask

    task automatic send_op(btk_op_t op);
        in_beat_t b;
        b = noise_beat();
        b.op = op;
        send_beat(b);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [23:0] period, logic sos);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ALARM_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_index <= CFG_START_ON_SYNC;
        cfg_wdata <= {23'b0, sos};
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_config(period, sos);
    endtask

    initial begin
        logic [23:0] phase_period [RAND_PHASES];
        logic        phase_sos [RAND_PHASES];
        in_beat_t    b;

        phase_period = '{24'd1, 24'd5, 24'd16777215, 24'd2, 24'd12, 24'd3};
        phase_sos = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold_req = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stopped clock with reset settings
        send_op(OP_TICK);
        send_op(OP_NOP);
        b = '0;
        b.op = OP_SYNC;
        send_beat(b);
        b = '1;
        b.op = OP_SYNC;
        send_beat(b);
        send_op(OP_TICK);
        wait_drained();

        // sync starts the clock, then wrap past the end of the day
        write_cfg(24'd1, 1'b1);
        send_beat(sync_at(DAY_END_UNIX_S, 32'd0));
        send_op(OP_TICK);
        send_op(OP_TICK);
        send_op(OP_START);
        send_op(OP_NOP);
        send_beat(sync_at(32'd1000000, 32'h8000_0000));
        send_op(OP_TICK);
        wait_drained();

        // zero period acts like one
        write_cfg(24'd0, 1'b0);
        repeat (3) send_op(OP_TICK);
        wait_drained();

        // period lowered below the prescaler
        write_cfg(24'd10, 1'b0);
        repeat (7) send_op(OP_TICK);
        wait_drained();
        write_cfg(24'd3, 1'b0);
        repeat (2) send_op(OP_TICK);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_cfg(phase_period[ph], phase_sos[ph]);
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if (i % 45 == 0) begin
                    tx_idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
                    rx_idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                if (ph == 1 && i == 100) begin
                    rx_hold_req = 1'b1;
                    tx_idle_on = 1'b0;
                end
                if (ph == 2 && i == 135) begin
                    wait_drained();
                end
                send_beat(random_beat());
            end
            wait_drained();
        end

        $display("%0d beats in, %0d results checked: %0d syncs, %0d beat advances, %0d day wraps",
                 sb.beats_in, sb.results_checked, sb.syncs, sb.advances, sb.wraps);
        $display("periods 0, 1 and the maximum, with start on sync both off and on");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
